[rtl/page_mapped_ftl_write_assert.svh]
// Assertion macros used by the pmftl_checker module of this block.
`ifndef PAGE_MAPPED_FTL_WRITE_ASSERT_SVH
`define PAGE_MAPPED_FTL_WRITE_ASSERT_SVH

// Check while out of reset.
`define PMFTL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pmftl assertion failed");

// Check at every edge, reset included.
`define PMFTL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("pmftl assertion failed");

`endif

[rtl/pmftl_pkg.sv]
package pmftl_pkg;

  localparam int LBA_W    = 4;
  localparam int PHYS_W   = 5;
  localparam int MOVED_W  = 6;
  localparam int ERASED_W = 4;
  localparam int TOTAL_W  = 32;
  localparam int WEAR_W   = 16;
  localparam int MINE_W   = 3;

  localparam logic [MINE_W-1:0] MIN_ERASED_RESET = 3'd2;

  localparam logic [MOVED_W-1:0]  MOVED_MAX  = '1;
  localparam logic [ERASED_W-1:0] ERASED_MAX = '1;

  localparam logic [2:0] REG_MIN_ERASED = 3'd0;

  typedef enum logic [1:0] {
    PG_FREE  = 2'd0,
    PG_VALID = 2'd1,
    PG_STALE = 2'd2
  } pg_st_t;

  typedef enum logic {
    ST_OK      = 1'b0,
    ST_NO_ROOM = 1'b1
  } wr_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_E,
    S_CHECK,
    S_PROG,
    S_PROG2,
    S_GCS,
    S_GCCHK,
    S_SCAN_V,
    S_VEND,
    S_RELOC,
    S_ERASE,
    S_ERASE_END,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic             vld;
    logic [LBA_W-1:0] lba;
  } q_t;

endpackage

[rtl/pmftl_if.sv]
interface pmftl_in_if;
  import pmftl_pkg::*;
  logic             valid;
  logic             ready;
  logic [LBA_W-1:0] lba;
  modport source (output valid, output lba, input ready);
  modport sink (input valid, input lba, output ready);
endinterface

interface pmftl_out_if;
  import pmftl_pkg::*;
  logic                valid;
  logic                ready;
  logic [PHYS_W-1:0]   physical_page;
  logic [MOVED_W-1:0]  pages_moved;
  logic [ERASED_W-1:0] blocks_erased;
  logic [TOTAL_W-1:0]  host_write_total;
  logic [TOTAL_W-1:0]  nand_write_total;
  logic                status;
  modport source (output valid, output physical_page, output pages_moved,
                  output blocks_erased, output host_write_total,
                  output nand_write_total, output status, input ready);
  modport sink (input valid, input physical_page, input pages_moved,
                input blocks_erased, input host_write_total,
                input nand_write_total, input status, output ready);
endinterface

[rtl/page_mapped_ftl_write.sv]
// channel  | dir | beat contents
// in_beat  | in  | lba
// out_beat | out | physical_page, pages_moved, blocks_erased, totals, status
// apb      | in  | min_erased_blocks at byte address 0
//
// One write runs a free-block scan, then per collection round a free-block
// scan, a victim scan over the pages of the blocks, and a relocation walk and
// an erase walk over the victim's pages, with a program sequence per relocated
// page; the back-end sequencer walks one page or block per cycle.
// A two-beat queue lets the front take writes while the back is busy.
// Synchronous active-low reset; the result register holds under stall.
module page_mapped_ftl_write #(
  parameter int BLOCK_COUNT     = 8,
  parameter int PAGES_PER_BLOCK = 4,
  parameter int LBA_COUNT       = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pmftl_in_if.sink    in_beat,
  pmftl_out_if.source out_beat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pmftl_pkg::*;

  q_t                q;
  logic              pop;
  logic [MINE_W-1:0] min_r;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MIN_ERASED) ? 32'(min_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_ERASED_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_MIN_ERASED[2]) begin
      min_r <= pwdata[MINE_W-1:0];
    end
  end

  pmftl_front #(.LBA_COUNT(LBA_COUNT)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_beat (in_beat),
    .q       (q),
    .pop     (pop)
  );

  pmftl_back #(
    .BLOCK_COUNT     (BLOCK_COUNT),
    .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
    .LBA_COUNT       (LBA_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q          (q),
    .pop        (pop),
    .min_erased (min_r),
    .out_beat   (out_beat)
  );

endmodule

[rtl/pmftl_front.sv]
module pmftl_front #(
  parameter int LBA_COUNT = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  pmftl_in_if.sink      in_beat,
  output pmftl_pkg::q_t q,
  input  logic          pop
);
  import pmftl_pkg::*;

  logic [LBA_W-1:0] slot_r [2];
  logic             rd_r, wr_r;
  logic [1:0]       cnt_r;
  logic             push;
  logic [LBA_W-1:0] lba_mod;

  function automatic logic [LBA_W-1:0] reduce(input logic [LBA_W-1:0] a);
    logic [10:0] v;
    v = 11'(a);
    for (int k = 0; k < 8; k++) begin
      if (v >= 11'(LBA_COUNT)) v = v - 11'(LBA_COUNT);
    end
    return v[LBA_W-1:0];
  endfunction

  assign lba_mod        = reduce(in_beat.lba);
  assign in_beat.ready  = (cnt_r != 2'd2);
  assign push           = in_beat.valid && in_beat.ready;
  assign q.vld          = (cnt_r != 2'd0);
  assign q.lba          = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= lba_mod;
  end

endmodule

[rtl/pmftl_back.sv]
module pmftl_back #(
  parameter int BLOCK_COUNT     = 8,
  parameter int PAGES_PER_BLOCK = 4,
  parameter int LBA_COUNT       = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pmftl_pkg::q_t               q,
  output logic                        pop,
  input  logic [pmftl_pkg::MINE_W-1:0] min_erased,
  pmftl_out_if.source                 out_beat
);
  import pmftl_pkg::*;

  localparam int TP  = BLOCK_COUNT * PAGES_PER_BLOCK;
  localparam int BW  = $clog2(BLOCK_COUNT);
  localparam int PGW = $clog2(PAGES_PER_BLOCK);
  localparam int AW  = $clog2(TP);
  localparam int LW  = $clog2(LBA_COUNT);
  localparam int FW  = $clog2(PAGES_PER_BLOCK + 1);
  localparam int ECW = $clog2(BLOCK_COUNT + 1);
  localparam int RW  = $clog2(TP + PAGES_PER_BLOCK + 1) + 1;
  localparam logic [BW-1:0]  LASTB = BW'(BLOCK_COUNT - 1);
  localparam logic [PGW-1:0] LASTP = PGW'(PAGES_PER_BLOCK - 1);
  localparam logic [FW-1:0]  FULL  = FW'(PAGES_PER_BLOCK);

  pg_st_t            pst_m  [TP];
  logic [LW-1:0]     own_m  [TP];
  logic [FW-1:0]     fill_m [BLOCK_COUNT];
  logic [WEAR_W-1:0] wear_m [BLOCK_COUNT];
  logic [AW-1:0]     map_m  [LBA_COUNT];
  logic              mapv_r [LBA_COUNT];

  fsm_t state_r, state_nxt, sret_r, sret_nxt, pret_r, pret_nxt;
  logic [LW-1:0]     lba_r, lba_nxt, plba_r, plba_nxt;
  logic [BW-1:0]     i_r, i_nxt, eb_r, eb_nxt, vb_r, vb_nxt, open_r, open_nxt;
  logic [PGW-1:0]    p_r, p_nxt;
  logic [ECW-1:0]    ec_r, ec_nxt;
  logic [WEAR_W-1:0] ew_r, ew_nxt, vw_r, vw_nxt;
  logic              ef_r, ef_nxt, vf_r, vf_nxt, fail_r, fail_nxt;
  logic [FW-1:0]     vm_r, vm_nxt, vl_r, vl_nxt, cs_r, cs_nxt, cl_r, cl_nxt;
  logic [FW-1:0]     of_r, of_nxt;
  logic [MOVED_W-1:0]  mv_r, mv_nxt;
  logic [ERASED_W-1:0] er_r, er_nxt;
  logic [TOTAL_W-1:0]  host_r, host_nxt, nand_r, nand_nxt;

  logic                ov_r, ov_nxt;
  logic [PHYS_W-1:0]   opp_r, opp_nxt;
  logic [MOVED_W-1:0]  omv_r, omv_nxt;
  logic [ERASED_W-1:0] oer_r, oer_nxt;
  logic [TOTAL_W-1:0]  oh_r, oh_nxt, on_r, on_nxt;
  logic                ost_r, ost_nxt;

  logic          pst_we, own_we, fill_we, wear_we, map_we;
  logic [AW-1:0] pst_wa, own_wa;
  pg_st_t        pst_wd;
  logic [LW-1:0] own_wd;
  logic [BW-1:0] fill_wa, wear_wa;
  logic [FW-1:0] fill_wd;

  logic [AW-1:0]     a_v, a_vic, a_prog;
  pg_st_t            st_v, st_vic;
  logic [FW-1:0]     stale_c, live_c;
  logic [RW-1:0]     room;
  logic [AW+PHYS_W-1:0] phys_ext;

  function automatic logic [AW-1:0] paddr_of(input logic [BW-1:0] b,
                                             input logic [PGW-1:0] p);
    return AW'(b) * AW'(PAGES_PER_BLOCK) + AW'(p);
  endfunction

  assign a_v      = paddr_of(i_r, p_r);
  assign a_vic    = paddr_of(vb_r, p_r);
  assign a_prog   = paddr_of(open_r, of_r[PGW-1:0]);
  assign st_v     = pst_m[a_v];
  assign st_vic   = pst_m[a_vic];
  assign stale_c  = cs_r + FW'(st_v == PG_STALE);
  assign live_c   = cl_r + FW'(st_v == PG_VALID);
  assign room     = RW'(FULL - of_r) + RW'(ec_r) * RW'(PAGES_PER_BLOCK);
  assign phys_ext = (AW + PHYS_W)'(map_m[lba_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sret_r  <= S_IDLE;
      pret_r  <= S_IDLE;
      open_r  <= '0;
      of_r    <= '0;
      host_r  <= '0;
      nand_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sret_r  <= sret_nxt;
      pret_r  <= pret_nxt;
      open_r  <= open_nxt;
      of_r    <= of_nxt;
      host_r  <= host_nxt;
      nand_r  <= nand_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lba_r  <= lba_nxt;
    plba_r <= plba_nxt;
    i_r    <= i_nxt;
    p_r    <= p_nxt;
    eb_r   <= eb_nxt;
    vb_r   <= vb_nxt;
    ec_r   <= ec_nxt;
    ew_r   <= ew_nxt;
    vw_r   <= vw_nxt;
    ef_r   <= ef_nxt;
    vf_r   <= vf_nxt;
    fail_r <= fail_nxt;
    vm_r   <= vm_nxt;
    vl_r   <= vl_nxt;
    cs_r   <= cs_nxt;
    cl_r   <= cl_nxt;
    mv_r   <= mv_nxt;
    er_r   <= er_nxt;
    opp_r  <= opp_nxt;
    omv_r  <= omv_nxt;
    oer_r  <= oer_nxt;
    oh_r   <= oh_nxt;
    on_r   <= on_nxt;
    ost_r  <= ost_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TP; k++) pst_m[k] <= PG_FREE;
      for (int k = 0; k < BLOCK_COUNT; k++) begin
        fill_m[k] <= '0;
        wear_m[k] <= '0;
      end
      for (int k = 0; k < LBA_COUNT; k++) mapv_r[k] <= 1'b0;
    end else begin
      if (pst_we)  pst_m[pst_wa]   <= pst_wd;
      if (fill_we) fill_m[fill_wa] <= fill_wd;
      if (wear_we) wear_m[wear_wa] <= wear_m[wear_wa] + WEAR_W'(1);
      if (map_we)  mapv_r[plba_r]  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (own_we) own_m[own_wa] <= own_wd;
    if (map_we) map_m[plba_r] <= a_prog;
  end

  always_comb begin
    state_nxt = state_r;
    sret_nxt  = sret_r;
    pret_nxt  = pret_r;
    lba_nxt   = lba_r;
    plba_nxt  = plba_r;
    i_nxt     = i_r;
    p_nxt     = p_r;
    eb_nxt    = eb_r;
    vb_nxt    = vb_r;
    ec_nxt    = ec_r;
    ew_nxt    = ew_r;
    vw_nxt    = vw_r;
    ef_nxt    = ef_r;
    vf_nxt    = vf_r;
    fail_nxt  = fail_r;
    vm_nxt    = vm_r;
    vl_nxt    = vl_r;
    cs_nxt    = cs_r;
    cl_nxt    = cl_r;
    open_nxt  = open_r;
    of_nxt    = of_r;
    mv_nxt    = mv_r;
    er_nxt    = er_r;
    host_nxt  = host_r;
    nand_nxt  = nand_r;
    ov_nxt    = ov_r && !out_beat.ready;
    opp_nxt   = opp_r;
    omv_nxt   = omv_r;
    oer_nxt   = oer_r;
    oh_nxt    = oh_r;
    on_nxt    = on_r;
    ost_nxt   = ost_r;
    pop       = 1'b0;
    pst_we    = 1'b0;
    pst_wa    = a_prog;
    pst_wd    = PG_VALID;
    own_we    = 1'b0;
    own_wa    = a_prog;
    own_wd    = plba_r;
    fill_we   = 1'b0;
    fill_wa   = open_r;
    fill_wd   = of_r + FW'(1);
    wear_we   = 1'b0;
    wear_wa   = vb_r;
    map_we    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q.vld) begin
          pop       = 1'b1;
          lba_nxt   = LW'(q.lba);
          mv_nxt    = '0;
          er_nxt    = '0;
          i_nxt     = '0;
          ec_nxt    = '0;
          ef_nxt    = 1'b0;
          sret_nxt  = S_CHECK;
          state_nxt = S_SCAN_E;
        end
      end
      S_SCAN_E: begin
        if (i_r != open_r && fill_m[i_r] == '0) begin
          ec_nxt = ec_r + ECW'(1);
          if (!ef_r || wear_m[i_r] < ew_r) begin
            eb_nxt = i_r;
            ew_nxt = wear_m[i_r];
            ef_nxt = 1'b1;
          end
        end
        if (i_r == LASTB) state_nxt = sret_r;
        else i_nxt = i_r + BW'(1);
      end
      S_CHECK: begin
        if (of_r == FULL && !ef_r) begin
          fail_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          fail_nxt = 1'b0;
          host_nxt = host_r + TOTAL_W'(1);
          if (mapv_r[lba_r]) begin
            pst_we = 1'b1;
            pst_wa = map_m[lba_r];
            pst_wd = PG_STALE;
          end
          plba_nxt  = lba_r;
          pret_nxt  = S_GCS;
          state_nxt = S_PROG;
        end
      end
      S_PROG: begin
        if (of_r == FULL) begin
          i_nxt     = '0;
          ec_nxt    = '0;
          ef_nxt    = 1'b0;
          sret_nxt  = S_PROG2;
          state_nxt = S_SCAN_E;
        end else begin
          state_nxt = S_PROG2;
        end
      end
      S_PROG2: begin
        if (of_r == FULL) begin
          if (ef_r) begin
            open_nxt = eb_r;
            of_nxt   = '0;
          end else begin
            state_nxt = pret_r;
          end
        end else begin
          pst_we    = 1'b1;
          own_we    = 1'b1;
          fill_we   = 1'b1;
          map_we    = 1'b1;
          of_nxt    = of_r + FW'(1);
          nand_nxt  = nand_r + TOTAL_W'(1);
          state_nxt = pret_r;
        end
      end
      S_GCS: begin
        i_nxt     = '0;
        ec_nxt    = '0;
        ef_nxt    = 1'b0;
        sret_nxt  = S_GCCHK;
        state_nxt = S_SCAN_E;
      end
      S_GCCHK: begin
        if (8'(ec_r) < 8'(min_erased)) begin
          i_nxt     = '0;
          p_nxt     = '0;
          vf_nxt    = 1'b0;
          vm_nxt    = '0;
          cs_nxt    = '0;
          cl_nxt    = '0;
          state_nxt = S_SCAN_V;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN_V: begin
        if (i_r == open_r || p_r == LASTP) begin
          if (i_r != open_r && ((stale_c > vm_r) ||
              (vf_r && stale_c == vm_r && wear_m[i_r] < vw_r))) begin
            vb_nxt = i_r;
            vm_nxt = stale_c;
            vw_nxt = wear_m[i_r];
            vl_nxt = live_c;
            vf_nxt = 1'b1;
          end
          cs_nxt = '0;
          cl_nxt = '0;
          p_nxt  = '0;
          if (i_r == LASTB) state_nxt = S_VEND;
          else i_nxt = i_r + BW'(1);
        end else begin
          cs_nxt = stale_c;
          cl_nxt = live_c;
          p_nxt  = p_r + PGW'(1);
        end
      end
      S_VEND: begin
        p_nxt = '0;
        if (!vf_r || RW'(vl_r) > room) state_nxt = S_DONE;
        else state_nxt = S_RELOC;
      end
      S_RELOC: begin
        if (st_vic == PG_VALID) begin
          plba_nxt  = own_m[a_vic];
          if (mv_r != MOVED_MAX) mv_nxt = mv_r + MOVED_W'(1);
          pret_nxt  = S_RELOC;
          state_nxt = S_PROG;
          pst_we    = 1'b1;
          pst_wa    = a_vic;
          pst_wd    = PG_FREE;
        end else if (p_r == LASTP) begin
          p_nxt     = '0;
          state_nxt = S_ERASE;
        end else begin
          p_nxt = p_r + PGW'(1);
        end
      end
      S_ERASE: begin
        pst_we = 1'b1;
        pst_wa = a_vic;
        pst_wd = PG_FREE;
        own_we = 1'b1;
        own_wa = a_vic;
        own_wd = '0;
        if (p_r == LASTP) state_nxt = S_ERASE_END;
        else p_nxt = p_r + PGW'(1);
      end
      S_ERASE_END: begin
        fill_we = 1'b1;
        fill_wa = vb_r;
        fill_wd = '0;
        wear_we = 1'b1;
        if (er_r != ERASED_MAX) er_nxt = er_r + ERASED_W'(1);
        state_nxt = S_GCS;
      end
      S_DONE: begin
        if (!ov_r || out_beat.ready) begin
          ov_nxt    = 1'b1;
          opp_nxt   = fail_r ? '0 : phys_ext[PHYS_W-1:0];
          omv_nxt   = mv_r;
          oer_nxt   = er_r;
          oh_nxt    = host_r;
          on_nxt    = nand_r;
          ost_nxt   = fail_r ? ST_NO_ROOM : ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_beat.valid            = ov_r;
  assign out_beat.physical_page    = opp_r;
  assign out_beat.pages_moved      = omv_r;
  assign out_beat.blocks_erased    = oer_r;
  assign out_beat.host_write_total = oh_r;
  assign out_beat.nand_write_total = on_r;
  assign out_beat.status           = ost_r;

endmodule

[rtl/pmftl_checker.sv]
`include "page_mapped_ftl_write_assert.svh"

module pmftl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] out_page,
  input logic [5:0] out_moved,
  input logic [3:0] out_erased,
  input logic       out_status
);

  `PMFTL_ASSERT(a_drop_clean, out_valid && out_status |-> out_page == 5'd0 && out_moved == 6'd0 && out_erased == 4'd0)
  `PMFTL_ASSERT(a_move_needs_erase, out_valid && out_erased == 4'd0 |-> out_moved == 6'd0)
  `PMFTL_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_page))
  `PMFTL_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid)

endmodule

bind page_mapped_ftl_write pmftl_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_beat.valid),
  .out_ready  (out_beat.ready),
  .out_page   (out_beat.physical_page),
  .out_moved  (out_beat.pages_moved),
  .out_erased (out_beat.blocks_erased),
  .out_status (out_beat.status)
);

[dv/pmftl_write_checker.sv]
module pmftl_write_checker
  import pmftl_pkg::*;
#(
  parameter int BLOCK_COUNT     = 8,
  parameter int PAGES_PER_BLOCK = 4,
  parameter int LBA_COUNT       = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pmftl_in_if         in_mon,
  pmftl_out_if        out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  localparam int TOTAL_PAGES = BLOCK_COUNT * PAGES_PER_BLOCK;

  typedef struct packed {
    logic [PHYS_W-1:0]   physical_page;
    logic [MOVED_W-1:0]  pages_moved;
    logic [ERASED_W-1:0] blocks_erased;
    logic [TOTAL_W-1:0]  host_write_total;
    logic [TOTAL_W-1:0]  nand_write_total;
    wr_status_t          status;
  } write_result_t;

  pg_st_t             pg_state [TOTAL_PAGES];
  logic [LBA_W-1:0]   pg_lba [TOTAL_PAGES];
  int unsigned        fill [BLOCK_COUNT];
  logic [WEAR_W-1:0]  wear [BLOCK_COUNT];
  int unsigned        lba_page [LBA_COUNT];
  bit                 lba_mapped [LBA_COUNT];
  int unsigned        open_blk;
  logic [TOTAL_W-1:0] hosts;
  logic [TOTAL_W-1:0] programs;
  logic [MINE_W-1:0]  min_erased;
  write_result_t      expected_results [$];

  function automatic int unsigned erased_spares();
    int unsigned n;
    n = 0;
    for (int i = 0; i < BLOCK_COUNT; i++)
      if (i != open_blk && fill[i] == 0) n++;
    return n;
  endfunction

  function automatic int least_worn_erased();
    int b;
    b = -1;
    for (int i = 0; i < BLOCK_COUNT; i++) begin
      if (i == open_blk || fill[i] != 0) continue;
      if (b < 0 || wear[i] < wear[b]) b = i;
    end
    return b;
  endfunction

  function automatic int greedy_victim();
    int b;
    int unsigned most;
    int unsigned st;
    b = -1;
    most = 0;
    for (int i = 0; i < BLOCK_COUNT; i++) begin
      if (i == open_blk) continue;
      st = 0;
      for (int p = 0; p < PAGES_PER_BLOCK; p++)
        if (pg_state[i*PAGES_PER_BLOCK+p] == PG_STALE) st++;
      if (st > most || (b >= 0 && st == most && wear[i] < wear[b])) begin
        most = st;
        b = i;
      end
    end
    return b;
  endfunction

  function automatic void program_lba(int unsigned a);
    int e;
    int unsigned pg;
    if (fill[open_blk] >= PAGES_PER_BLOCK) begin
      e = least_worn_erased();
      if (e < 0) return;
      open_blk = e;
    end
    pg = open_blk * PAGES_PER_BLOCK + fill[open_blk];
    pg_state[pg] = PG_VALID;
    pg_lba[pg] = LBA_W'(a);
    lba_page[a] = pg;
    lba_mapped[a] = 1'b1;
    fill[open_blk]++;
    programs++;
  endfunction

  function automatic write_result_t host_write(logic [LBA_W-1:0] lba_in);
    write_result_t r;
    int unsigned a, moved, erased, base, live, room;
    int v;
    a = lba_in % LBA_COUNT;
    moved = 0;
    erased = 0;
    r = '0;
    if (fill[open_blk] >= PAGES_PER_BLOCK && least_worn_erased() < 0) begin
      r.host_write_total = hosts;
      r.nand_write_total = programs;
      r.status = ST_NO_ROOM;
      return r;
    end
    hosts++;
    if (lba_mapped[a] && lba_page[a] < TOTAL_PAGES) pg_state[lba_page[a]] = PG_STALE;
    program_lba(a);
    while (erased_spares() < min_erased) begin
      v = greedy_victim();
      if (v < 0) break;
      base = v * PAGES_PER_BLOCK;
      live = 0;
      for (int p = 0; p < PAGES_PER_BLOCK; p++)
        if (pg_state[base+p] == PG_VALID) live++;
      room = (PAGES_PER_BLOCK - fill[open_blk]) + erased_spares() * PAGES_PER_BLOCK;
      if (live > room) break;
      for (int p = 0; p < PAGES_PER_BLOCK; p++)
        if (pg_state[base+p] == PG_VALID) begin
          program_lba(pg_lba[base+p] % LBA_COUNT);
          if (moved < 63) moved++;
        end
      for (int p = 0; p < PAGES_PER_BLOCK; p++) begin
        pg_state[base+p] = PG_FREE;
        pg_lba[base+p] = '0;
      end
      fill[v] = 0;
      wear[v] = wear[v] + 1'b1;
      if (erased < 15) erased++;
    end
    r.physical_page = lba_page[a][PHYS_W-1:0];
    r.pages_moved = MOVED_W'(moved);
    r.blocks_erased = ERASED_W'(erased);
    r.host_write_total = hosts;
    r.nand_write_total = programs;
    r.status = ST_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    write_result_t exp_r, act_r;
    if (!rst_n) begin
      for (int i = 0; i < TOTAL_PAGES; i++) begin
        pg_state[i] = PG_FREE;
        pg_lba[i] = '0;
      end
      for (int i = 0; i < BLOCK_COUNT; i++) begin
        fill[i] = 0;
        wear[i] = '0;
      end
      for (int i = 0; i < LBA_COUNT; i++) begin
        lba_page[i] = 0;
        lba_mapped[i] = 1'b0;
      end
      open_blk = 0;
      hosts = '0;
      programs = '0;
      min_erased = MIN_ERASED_RESET;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
        min_erased = pwdata[MINE_W-1:0];
      if (out_mon.valid && out_mon.ready) begin
        act_r.physical_page = out_mon.physical_page;
        act_r.pages_moved = out_mon.pages_moved;
        act_r.blocks_erased = out_mon.blocks_erased;
        act_r.host_write_total = out_mon.host_write_total;
        act_r.nand_write_total = out_mon.nand_write_total;
        act_r.status = wr_status_t'(out_mon.status);
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %p", act_r);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (act_r !== exp_r) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", exp_r, act_r);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) expected_results.push_back(host_write(in_mon.lba));
    end
    pending <= expected_results.size();
  end

endmodule

[dv/tb_page_mapped_ftl_write.sv]
module tb_page_mapped_ftl_write;
  import pmftl_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending;
  bit          allow_idle;
  int          stall_left;
  int unsigned quiet_cycles;

  pmftl_in_if  in_beat ();
  pmftl_out_if out_beat ();

  page_mapped_ftl_write dut (
    .clk(clk), .rst_n(rst_n), .in_beat(in_beat), .out_beat(out_beat),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pmftl_write_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_beat), .out_mon(out_beat),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_beat.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_beat.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (allow_idle && $urandom_range(0, 9) == 0) begin
      out_beat.ready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_beat.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_beat.valid && in_beat.ready) || (out_beat.valid && out_beat.ready)
        || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb_page_mapped_ftl_write failed");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0 || in_beat.valid || chk.expected_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_lba(logic [LBA_W-1:0] a);
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      in_beat.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_beat.valid <= 1'b1;
    in_beat.lba <= a;
    do @(posedge clk); while (!in_beat.ready);
  endtask

  function automatic logic [LBA_W-1:0] pick_lba();
    if ($urandom_range(0, 9) < 6) return LBA_W'($urandom_range(0, 3));
    return LBA_W'($urandom_range(0, 15));
  endfunction

  initial begin
    logic [MINE_W-1:0] settings [7];
    settings = '{3'd2, 3'd1, 3'd6, 3'd3, 3'd5, 3'd4, 3'd0};
    rst_n = 1'b0;
    in_beat.valid = 1'b0;
    in_beat.lba = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    allow_idle = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    reg_write(3'd4, 32'd0);
    @(posedge clk);
    foreach (settings[i]) begin
      reg_write({REG_MIN_ERASED[0], 2'b00}, 32'(settings[i]));
      if (i == 0) begin
        for (int k = 0; k < 4; k++) write_lba(4'd0);
        write_lba(4'd15);
        write_lba(4'd15);
        for (int k = 0; k < 16; k++) write_lba(LBA_W'(k));
      end
      if (i == 6) allow_idle = 1'b0;
      for (int k = 0; k < 275; k++) write_lba(pick_lba());
      in_beat.valid <= 1'b0;
      @(posedge clk);
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_page_mapped_ftl_write passed");
    end else begin
      $display("tb_page_mapped_ftl_write failed");
    end
    $finish;
  end

endmodule
